[hw/rtl/hts_pkg.sv]
`timescale 1ns / 1ps

package hts_pkg;

    // node index and symbol widths, fixed by the largest supported tree
    localparam int IDX_W           = 9;
    localparam int SYM_W           = 8;
    localparam int DEF_MAX_SYMBOLS = 256;

    // parse phase codes
    localparam logic [1:0] PH_NODE  = 2'd0;
    localparam logic [1:0] PH_LEAF  = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_STALL = 2'd3;

    // write request into the node table
    typedef struct packed {
        logic             ent_we;
        logic [IDX_W-1:0] ent_addr;
        logic             ent_leaf;
        logic [SYM_W-1:0] ent_sym;
        logic             left_we;
        logic             right_we;
        logic [IDX_W-1:0] link_addr;
        logic [IDX_W-1:0] link_val;
    } node_wr_t;

    // registered read of one node
    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_rd_t;

endpackage

[hw/rtl/hts_node_ram.sv]
`timescale 1ns / 1ps

module hts_node_ram #(
    parameter int DEPTH = 2 * hts_pkg::DEF_MAX_SYMBOLS - 1
) (
    input  logic                     aclk,
    input  hts_pkg::node_wr_t        wr,
    input  logic [hts_pkg::IDX_W-1:0] rd_addr,
    output hts_pkg::node_rd_t        rd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [hts_pkg::SYM_W:0]   ent_mem   [DEPTH];
    logic [hts_pkg::IDX_W-1:0] left_mem  [DEPTH];
    logic [hts_pkg::IDX_W-1:0] right_mem [DEPTH];

    // leaf flag and symbol, written when the node is created; child links written as children are attached
    always_ff @(posedge aclk) begin
        if (wr.ent_we) begin
            ent_mem[wr.ent_addr[AW-1:0]] <= {wr.ent_leaf, wr.ent_sym};
        end
        if (wr.left_we) begin
            left_mem[wr.link_addr[AW-1:0]] <= wr.link_val;
        end
        if (wr.right_we) begin
            right_mem[wr.link_addr[AW-1:0]] <= wr.link_val;
        end
    end

    always_ff @(posedge aclk) begin
        {rd.leaf, rd.sym} <= ent_mem[rd_addr[AW-1:0]];
        rd.left           <= left_mem[rd_addr[AW-1:0]];
        rd.right          <= right_mem[rd_addr[AW-1:0]];
    end

endmodule

[hw/rtl/hts_stack_ram.sv]
`timescale 1ns / 1ps

module hts_stack_ram #(
    parameter int DEPTH = hts_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [hts_pkg::IDX_W:0]   wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [hts_pkg::IDX_W:0]   rd_data
);

    // entry: {left child attached, node index}
    logic [hts_pkg::IDX_W:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/huffman_tree_stream_decoder_core.sv]
`timescale 1ns / 1ps

// huffman stream decoder with a pre-order tree header
// s_axis: one compressed byte per transfer, tdata = data_byte, tuser = new_stream;
//   new_stream clears the tree and parses a fresh header starting with that byte
// m_axis: decoded symbols, tdata = symbol, tlast marks the final symbol of a byte;
//   a byte gives zero to eight transfers
// bits are taken msb first, and each bit needs one registered
//   node-table read (child lookup) before it can be acted on
// a byte passes a read state and an execute state for each bit, then a closing
//   state, and a new byte is accepted only in the idle state
// the last symbol of a byte is held until the byte is done so that tlast can
//   be set
// the output register lets the next byte be taken while a result waits
// a stalled receiver freezes bit processing only when another symbol must leave
// reset clears the parse state; node table and build stack are not cleared,
//   since every entry is written by the header before it is read
// a header too large for the tables puts the block in a stalled phase that
//   drops all bits until the next new_stream

module huffman_tree_stream_decoder_core #(
    parameter int MAX_SYMBOLS = hts_pkg::DEF_MAX_SYMBOLS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] new_stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] symbol
    output logic       m_axis_tlast
);

    localparam int IDX_W    = hts_pkg::IDX_W;
    localparam int SYM_W    = hts_pkg::SYM_W;
    localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
    localparam int NU_W     = $clog2(NODE_CAP + 1);
    localparam int LVL_W    = $clog2(MAX_SYMBOLS + 1);
    localparam int SAW      = $clog2(MAX_SYMBOLS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EXE  = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [2:0]       bcnt_reg, bcnt_next;
    logic [7:0]       byte_reg, byte_next;
    logic [1:0]       phase_reg, phase_next;
    logic [NU_W-1:0]  used_reg, used_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [IDX_W:0]   top_reg, top_next;        // {attached, index}
    logic [SYM_W-1:0] lshift_reg, lshift_next;
    logic [2:0]       lcnt_reg, lcnt_next;

    // current walk node and root copies
    hts_pkg::node_rd_t cur_reg, cur_next;
    hts_pkg::node_rd_t root_reg, root_next;

    // last symbol found in this byte, not yet sent
    logic             pend_v_reg, pend_v_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;

    logic             mv_reg, mv_next;
    logic [SYM_W-1:0] msym_reg, msym_next;
    logic             mlast_reg, mlast_next;

    hts_pkg::node_wr_t nwr;
    hts_pkg::node_rd_t nrd;
    logic [IDX_W-1:0]  child;

    logic             stk_we;
    logic [SAW-1:0]   stk_wa;
    logic [IDX_W:0]   stk_wd;
    logic [SAW-1:0]   stk_ra;
    logic [IDX_W:0]   stk_rd;

    logic             in_xfer;
    logic             out_free;
    logic             bit_v;
    logic             do_add;
    logic             add_int;
    logic [SYM_W-1:0] add_sym;
    logic             hit;
    logic [SYM_W-1:0] hit_sym;
    logic [IDX_W-1:0] n_idx;

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !mv_reg || m_axis_tready;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = msym_reg;
    assign m_axis_tlast  = mlast_reg;

    assign bit_v  = byte_reg[7];
    assign child  = bit_v ? cur_reg.right : cur_reg.left;
    assign stk_ra = SAW'(lvl_reg - LVL_W'(2));
    assign n_idx  = IDX_W'(used_reg);

    hts_node_ram #(
        .DEPTH (NODE_CAP)
    ) u_node_ram (
        .aclk    (aclk),
        .wr      (nwr),
        .rd_addr (child),
        .rd      (nrd)
    );

    hts_stack_ram #(
        .DEPTH (MAX_SYMBOLS)
    ) u_stack_ram (
        .aclk    (aclk),
        .we      (stk_we),
        .wr_addr (stk_wa),
        .wr_data (stk_wd),
        .rd_addr (stk_ra),
        .rd_data (stk_rd)
    );

    always_comb begin
        st_next       = st_reg;
        bcnt_next     = bcnt_reg;
        byte_next     = byte_reg;
        phase_next    = phase_reg;
        used_next     = used_reg;
        lvl_next      = lvl_reg;
        top_next      = top_reg;
        lshift_next   = lshift_reg;
        lcnt_next     = lcnt_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        pend_v_next   = pend_v_reg;
        pend_sym_next = pend_sym_reg;
        mv_next       = mv_reg && !m_axis_tready;
        msym_next     = msym_reg;
        mlast_next    = mlast_reg;
        nwr           = '0;
        stk_we        = 1'b0;
        stk_wa        = SAW'(lvl_reg - LVL_W'(1));
        stk_wd        = top_reg;
        do_add        = 1'b0;
        add_int       = 1'b0;
        add_sym       = '0;
        hit           = 1'b0;
        hit_sym       = '0;

        unique case (st_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    byte_next = s_axis_tdata;
                    bcnt_next = '0;
                    st_next   = ST_RD;
                    if (s_axis_tuser) begin
                        phase_next  = hts_pkg::PH_NODE;
                        used_next   = '0;
                        lvl_next    = '0;
                        lshift_next = '0;
                        lcnt_next   = '0;
                    end
                end
            end
            ST_RD: begin
                // node and stack reads settle during this cycle
                st_next = ST_EXE;
            end
            ST_EXE: begin
                case (phase_reg)
                    hts_pkg::PH_NODE: begin
                        if (bit_v) begin
                            phase_next  = hts_pkg::PH_LEAF;
                            lshift_next = '0;
                            lcnt_next   = '0;
                        end else begin
                            do_add  = 1'b1;
                            add_int = 1'b1;
                        end
                    end
                    hts_pkg::PH_LEAF: begin
                        lshift_next = {lshift_reg[SYM_W-2:0], bit_v};
                        lcnt_next   = lcnt_reg + 3'd1;
                        if (lcnt_reg == 3'd7) begin
                            do_add  = 1'b1;
                            add_sym = lshift_next;
                        end
                    end
                    hts_pkg::PH_DATA: begin
                        if (cur_reg.leaf) begin
                            hit     = 1'b1;
                            hit_sym = cur_reg.sym;
                        end else if (nrd.leaf) begin
                            hit     = 1'b1;
                            hit_sym = nrd.sym;
                        end
                    end
                    default: begin
                        // stalled phase drops the bit
                    end
                endcase

                if (hit && pend_v_reg && !out_free) begin
                    // wait for the receiver, nothing changes this cycle
                    lshift_next = lshift_reg;
                    lcnt_next   = lcnt_reg;
                    do_add      = 1'b0;
                end else begin
                    if (hit) begin
                        if (pend_v_reg) begin
                            mv_next    = 1'b1;
                            msym_next  = pend_sym_reg;
                            mlast_next = 1'b0;
                        end
                        pend_v_next   = 1'b1;
                        pend_sym_next = hit_sym;
                        cur_next      = root_reg;
                    end else if (phase_reg == hts_pkg::PH_DATA) begin
                        cur_next = nrd;
                    end
                    byte_next = {byte_reg[6:0], 1'b0};
                    bcnt_next = bcnt_reg + 3'd1;
                    st_next   = (bcnt_reg == 3'd7) ? ST_END : ST_RD;
                end

                if (do_add) begin
                    if (used_reg >= NU_W'(NODE_CAP) ||
                        (add_int && lvl_reg >= LVL_W'(MAX_SYMBOLS))) begin
                        phase_next = hts_pkg::PH_STALL;
                    end else begin
                        nwr.ent_we   = 1'b1;
                        nwr.ent_addr = n_idx;
                        nwr.ent_leaf = !add_int;
                        nwr.ent_sym  = add_sym;
                        used_next    = used_reg + NU_W'(1);
                        if (n_idx == '0) begin
                            root_next.leaf = !add_int;
                            root_next.sym  = add_sym;
                        end
                        nwr.link_addr = top_reg[IDX_W-1:0];
                        nwr.link_val  = n_idx;
                        if (lvl_reg == '0) begin
                            if (add_int) begin
                                top_next = {1'b0, n_idx};
                                lvl_next = LVL_W'(1);
                            end
                        end else if (!top_reg[IDX_W]) begin
                            nwr.left_we = 1'b1;
                            if (top_reg[IDX_W-1:0] == '0) begin
                                root_next.left = n_idx;
                            end
                            if (add_int) begin
                                // old top moves into the stack memory
                                stk_we   = 1'b1;
                                stk_wd   = {1'b1, top_reg[IDX_W-1:0]};
                                top_next = {1'b0, n_idx};
                                lvl_next = lvl_reg + LVL_W'(1);
                            end else begin
                                top_next = {1'b1, top_reg[IDX_W-1:0]};
                            end
                        end else begin
                            nwr.right_we = 1'b1;
                            if (top_reg[IDX_W-1:0] == '0) begin
                                root_next.right = n_idx;
                            end
                            if (add_int) begin
                                // pop and push in one step
                                top_next = {1'b0, n_idx};
                            end else begin
                                top_next = stk_rd;
                                lvl_next = lvl_reg - LVL_W'(1);
                            end
                        end
                        phase_next = (lvl_next == '0) ? hts_pkg::PH_DATA
                                                      : hts_pkg::PH_NODE;
                        if (lvl_next == '0) begin
                            cur_next = root_next;
                        end
                    end
                end
            end
            ST_END: begin
                if (!pend_v_reg) begin
                    st_next = ST_IDLE;
                end else if (out_free) begin
                    mv_next     = 1'b1;
                    msym_next   = pend_sym_reg;
                    mlast_next  = 1'b1;
                    pend_v_next = 1'b0;
                    st_next     = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            bcnt_reg   <= '0;
            phase_reg  <= hts_pkg::PH_NODE;
            used_reg   <= '0;
            lvl_reg    <= '0;
            lshift_reg <= '0;
            lcnt_reg   <= '0;
            pend_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
            cur_reg    <= '0;
            root_reg   <= '0;
        end else begin
            st_reg     <= st_next;
            bcnt_reg   <= bcnt_next;
            phase_reg  <= phase_next;
            used_reg   <= used_next;
            lvl_reg    <= lvl_next;
            lshift_reg <= lshift_next;
            lcnt_reg   <= lcnt_next;
            pend_v_reg <= pend_v_next;
            mv_reg     <= mv_next;
            cur_reg    <= cur_next;
            root_reg   <= root_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        top_reg      <= top_next;
        pend_sym_reg <= pend_sym_next;
        msym_reg     <= msym_next;
        mlast_reg    <= mlast_next;
    end

    // data decoding only runs with an empty build stack
    a_data_empty_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == hts_pkg::PH_DATA |-> lvl_reg == '0)
        else $error("data phase with open internal nodes");

    // an accepted byte starts bit processing
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> st_reg == ST_RD)
        else $error("accepted byte not processed");

    // no symbol is left behind when the block goes idle
    a_idle_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_IDLE |-> !pend_v_reg)
        else $error("pending symbol at idle");

    // the tree never outgrows the node table
    a_nodes_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && !s_axis_tuser |-> used_reg <= NU_W'(NODE_CAP))
        else $error("node count beyond table");

endmodule
